// ===== design/mcbd_pkg.sv =====
// Shared types and constants of the multi-click button detector.
// No dependencies; imported by the lane, the merge stage and the top level.
package mcbd_pkg;

    // Phase of one button, one-hot coded.
    typedef enum logic [4:0] {
        PH_AWAIT_PRESS   = 5'b00001,
        PH_DEB_PRESS     = 5'b00010,
        PH_AWAIT_RELEASE = 5'b00100,
        PH_DEB_RELEASE   = 5'b01000,
        PH_AWAIT_MULTI   = 5'b10000
    } phase_t;

    // Event kinds reported on the result channel.
    localparam logic [1:0] EV_CLICKS       = 2'd0;
    localparam logic [1:0] EV_HOLD         = 2'd1;
    localparam logic [1:0] EV_HOLD_RELEASE = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_ACTIVE_LEVELS = 3'd0;
    localparam logic [2:0] REG_DEB_PRESS     = 3'd1;
    localparam logic [2:0] REG_DEB_RELEASE   = 3'd2;
    localparam logic [2:0] REG_HOLD          = 3'd3;
    localparam logic [2:0] REG_MULTI_CLICK   = 3'd4;
    localparam logic [2:0] REG_MAX_CLICKS    = 3'd5;

    localparam logic [15:0] TIMER_MAX = 16'hFFFF;

    // Timing thresholds and the click limit shared by all lanes.
    typedef struct packed {
        logic [15:0] debounce_press_ms;
        logic [15:0] debounce_release_ms;
        logic [15:0] hold_ms;
        logic [15:0] multi_click_ms;
        logic [3:0]  max_clicks;
    } cfg_t;

    // Event found by one lane for the current tick.
    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [3:0] count;
    } lane_event_t;

endpackage

// ===== design/mcbd_lane.sv =====
// One button lane: phase machine, saturating timer and click counter.
// Depends on mcbd_pkg for the phase type, thresholds and event struct.
module mcbd_lane (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 tick,
    input  logic [15:0]          elapsed_ms,
    input  logic                 pressed,
    input  mcbd_pkg::cfg_t       cfg,
    output mcbd_pkg::lane_event_t ev
);
    import mcbd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  clicks_reg, clicks_next;
    logic        held_reg, held_next;
    logic [15:0] timer_reg, timer_next;
    logic [16:0] sum;
    logic [15:0] t;

    assign sum = {1'b0, timer_reg} + {1'b0, elapsed_ms};
    assign t   = sum[16] ? TIMER_MAX : sum[15:0];

    always_comb begin
        phase_next  = phase_reg;
        clicks_next = clicks_reg;
        held_next   = held_reg;
        timer_next  = t;
        ev          = '0;
        case (phase_reg)
            PH_DEB_PRESS: begin
                if (t > cfg.debounce_press_ms) begin
                    phase_next = PH_AWAIT_RELEASE;
                    timer_next = '0;
                end
            end
            PH_AWAIT_RELEASE: begin
                if (!pressed) begin
                    phase_next = PH_DEB_RELEASE;
                    timer_next = '0;
                end else if (t > cfg.hold_ms) begin
                    held_next  = 1'b1;
                    timer_next = '0;
                    ev.valid   = 1'b1;
                    ev.kind    = EV_HOLD;
                end
            end
            PH_DEB_RELEASE: begin
                if (t > cfg.debounce_release_ms) begin
                    timer_next = '0;
                    if (held_reg) begin
                        phase_next  = PH_AWAIT_PRESS;
                        held_next   = 1'b0;
                        clicks_next = '0;
                        ev.valid    = 1'b1;
                        ev.kind     = EV_HOLD_RELEASE;
                    end else begin
                        clicks_next = (clicks_reg < cfg.max_clicks) ?
                                      clicks_reg + 4'd1 : cfg.max_clicks;
                        phase_next  = PH_AWAIT_MULTI;
                    end
                end
            end
            PH_AWAIT_MULTI: begin
                if (pressed) begin
                    phase_next = PH_DEB_PRESS;
                    timer_next = '0;
                end else if (t > cfg.multi_click_ms) begin
                    phase_next = PH_AWAIT_PRESS;
                    ev.valid   = 1'b1;
                    ev.kind    = EV_CLICKS;
                    ev.count   = clicks_reg;
                end
            end
            default: begin
                // Await press: a new sequence starts from a clean slate.
                phase_next  = PH_AWAIT_PRESS;
                clicks_next = '0;
                held_next   = 1'b0;
                if (pressed) begin
                    phase_next = PH_DEB_PRESS;
                    timer_next = '0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_AWAIT_PRESS;
            clicks_reg <= '0;
            held_reg   <= 1'b0;
            timer_reg  <= '0;
        end else if (tick) begin
            phase_reg  <= phase_next;
            clicks_reg <= clicks_next;
            held_reg   <= held_next;
            timer_reg  <= timer_next;
        end
    end

endmodule

// ===== design/mcbd_merge.sv =====
// Merge stage: holds one tick's events, sends them one per cycle while
// the receiver is ready, in ascending button order. Needs mcbd_pkg.
module mcbd_merge #(
    parameter int LANES = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  mcbd_pkg::lane_event_t lane_ev [LANES],
    output logic                  batch_empty,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            m_button_index,
    output logic [1:0]            m_event_kind,
    output logic [3:0]            m_click_count,
    output logic                  m_last
);
    import mcbd_pkg::*;

    logic [LANES-1:0] mask_reg, mask_next;
    logic [1:0]       kind_reg  [LANES];
    logic [3:0]       count_reg [LANES];
    logic             out_valid_reg;
    logic [2:0]       out_index_reg;
    logic [1:0]       out_kind_reg;
    logic [3:0]       out_count_reg;
    logic             out_last_reg;
    logic             move;
    logic             found;
    logic [2:0]       sel_index;
    logic [1:0]       sel_kind;
    logic [3:0]       sel_count;

    // Lowest pending button wins; its bit is cleared from the batch.
    always_comb begin
        found     = 1'b0;
        sel_index = '0;
        sel_kind  = '0;
        sel_count = '0;
        mask_next = mask_reg;
        for (int i = 0; i < LANES; i++) begin
            if (mask_reg[i] && !found) begin
                found        = 1'b1;
                sel_index    = 3'(i);
                sel_kind     = kind_reg[i];
                sel_count    = count_reg[i];
                mask_next[i] = 1'b0;
            end
        end
    end

    assign batch_empty = (mask_reg == '0);
    assign move        = !batch_empty && (!out_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                for (int i = 0; i < LANES; i++) begin
                    mask_reg[i] <= lane_ev[i].valid;
                end
            end else if (move) begin
                mask_reg <= mask_next;
            end
            if (move) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < LANES; i++) begin
                kind_reg[i]  <= lane_ev[i].kind;
                count_reg[i] <= lane_ev[i].count;
            end
        end
        if (move) begin
            out_index_reg <= sel_index;
            out_kind_reg  <= sel_kind;
            out_count_reg <= sel_count;
            out_last_reg  <= (mask_next == '0);
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_button_index = out_index_reg;
    assign m_event_kind   = out_kind_reg;
    assign m_click_count  = out_count_reg;
    assign m_last         = out_last_reg;

`ifndef SYNTHESIS
    a_load_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> batch_empty)
        else $error("new tick loaded over a pending batch");
    a_move_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        move |=> m_valid)
        else $error("event moved out but no result shown");
    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_event_kind == EV_CLICKS || m_event_kind == EV_HOLD ||
                     m_event_kind == EV_HOLD_RELEASE))
        else $error("illegal event kind on result channel");
    a_count_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_kind != EV_CLICKS) |-> (m_click_count == 4'd0))
        else $error("nonzero click count on hold event");
`endif

endmodule

// ===== design/multi_click_button_detector.sv =====
// Top level of the multi-click button detector: configuration registers,
// one lane per button and the merge stage. Depends on mcbd_pkg,
// mcbd_lane and mcbd_merge.
//
// Usage: every item on the s_ channel is one time tick carrying the
// milliseconds elapsed since the previous tick and the raw level of every
// button. Each button runs its own debounce and click machine; the events
// found in one tick (click sequence ended, hold, released after hold) come
// out on the m_ channel in ascending button order, one item each, with
// m_last set on the final event of the tick. A tick without events
// produces no item.
// The user writes configuration through the cfg_ channel, one register
// per item, only while the block is idle; the block does not enforce it.
// cfg_ready is always high and writes to unknown indexes are dropped.
// An accepted tick's events are captured in the merge stage's batch
// register, then move one by one into its output register, which
// drives the m_ channel. A tick with events holds s_ready low while the
// batch drains one event per cycle, while the receiver is ready,
// through the single result port; a tick may be accepted while the
// previous tick's last event still waits in the output register.
// Reset: all buttons return to await press with cleared timers and counts,
// and the registers take their default values. When the receiver stalls,
// the output item holds and s_ready drops once the next batch is waiting.
module multi_click_button_detector #(
    parameter int NUM_BUTTONS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_elapsed_ms,
    input  logic [7:0]  s_button_levels,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_button_index,
    output logic [1:0]  m_event_kind,
    output logic [3:0]  m_click_count,
    output logic        m_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import mcbd_pkg::*;

    // Only eight buttons fit the level and index fields.
    localparam int LANES = (NUM_BUTTONS > 8) ? 8 : NUM_BUTTONS;

    logic [7:0]  active_levels_reg;
    cfg_t        cfg_reg;
    logic        accept;
    logic        batch_empty;
    logic [7:0]  pressed;
    lane_event_t lane_ev [LANES];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_levels_reg           <= '0;
            cfg_reg.debounce_press_ms   <= 16'd50;
            cfg_reg.debounce_release_ms <= 16'd50;
            cfg_reg.hold_ms             <= 16'd1000;
            cfg_reg.multi_click_ms      <= 16'd300;
            cfg_reg.max_clicks          <= 4'd5;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ACTIVE_LEVELS: active_levels_reg <= cfg_data[7:0];
                REG_DEB_PRESS:     cfg_reg.debounce_press_ms <= cfg_data;
                REG_DEB_RELEASE:   cfg_reg.debounce_release_ms <= cfg_data;
                REG_HOLD:          cfg_reg.hold_ms <= cfg_data;
                REG_MULTI_CLICK:   cfg_reg.multi_click_ms <= cfg_data;
                REG_MAX_CLICKS:    cfg_reg.max_clicks <= cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // A new tick is taken whenever the previous tick's batch has been
    // handed to the output register.
    assign s_ready = batch_empty;
    assign accept  = s_valid && s_ready;

    // A button counts as pressed when its level equals its active level.
    assign pressed = ~(s_button_levels ^ active_levels_reg);

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        mcbd_lane u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .tick       (accept),
            .elapsed_ms (s_elapsed_ms),
            .pressed    (pressed[g]),
            .cfg        (cfg_reg),
            .ev         (lane_ev[g])
        );
    end

    mcbd_merge #(
        .LANES (LANES)
    ) u_merge (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (accept),
        .lane_ev        (lane_ev),
        .batch_empty    (batch_empty),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_button_index (m_button_index),
        .m_event_kind   (m_event_kind),
        .m_click_count  (m_click_count),
        .m_last         (m_last)
    );

endmodule

// ===== tb/multi_click_button_detector_tb.sv =====
// Self-checking testbench for multi_click_button_detector: directed and random ticks,
// a tick-by-tick model of all eight button machines, and event checking in order.
// Depends on mcbd_pkg and the multi_click_button_detector RTL.
module multi_click_button_detector_tb;
    import mcbd_pkg::*;

    // Run limits, in clock cycles, and a cap on printed errors.
    localparam int WATCHDOG_CYCLES = 500000;
    localparam int DRAIN_LIMIT     = 100000;
    localparam int SETTLE_CYCLES   = 16;
    localparam int MAX_PRINTED     = 40;

    // The receiver holds off once for a long stretch, starting when this many
    // ticks have been taken, so that the event batches pile up and s_ready drops.
    localparam int LONG_STALL_AT     = 60;
    localparam int LONG_STALL_CYCLES = 300;

    // One tick as the sender offers it.
    typedef struct packed {
        logic [15:0] elapsed;
        logic [7:0]  levels;
    } tick_t;

    // One event as the block should report it.
    typedef struct packed {
        logic [2:0] button;
        logic [1:0] kind;
        logic [3:0] count;
        logic       last;
    } btn_event_t;

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [15:0] s_elapsed_ms    = '0;
    logic [7:0]  s_button_levels = '0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [2:0]  m_button_index;
    logic [1:0]  m_event_kind;
    logic [3:0]  m_click_count;
    logic        m_last;
    logic        cfg_valid       = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index       = '0;
    logic [15:0] cfg_data        = '0;

    multi_click_button_detector #(
        .NUM_BUTTONS(8)
    ) dut (
        .*
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Button model: its own copy of the registers and of every button's
    // phase, click count, hold flag and saturating timer.
    // ------------------------------------------------------------------
    logic [7:0]  pressed_level;
    logic [15:0] settle_press;
    logic [15:0] settle_release;
    logic [15:0] hold_period;
    logic [15:0] quiet_gap;
    logic [3:0]  click_cap;

    phase_t      btn_phase [8];
    logic [3:0]  btn_clicks [8];
    logic        btn_held [8];
    logic [15:0] btn_timer [8];

    // Events that the block still owes, oldest first.
    btn_event_t pending_events [$];

    // Ticks waiting for the sender.
    tick_t pending_ticks [$];

    // Logical press state of each button that the random ticks follow.
    logic [7:0] finger_down = '0;

    int error_count   = 0;
    int ticks_taken   = 0;
    int events_taken  = 0;
    int cfg_writes    = 0;

    task automatic flag_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("ERROR at %0t: %s", $time, what);
    endtask

    // Advances all buttons by one tick and queues the events it causes,
    // buttons in ascending order, with the last one of the tick marked.
    function automatic void advance_buttons(input logic [15:0] elapsed,
                                            input logic [7:0] levels);
        btn_event_t  found [8];
        int          n;
        logic [16:0] sum;
        logic [15:0] t;
        logic        pressed;
        n = 0;
        for (int b = 0; b < 8; b++) begin
            pressed = ~(levels[b] ^ pressed_level[b]);
            sum = {1'b0, btn_timer[b]} + {1'b0, elapsed};
            t = sum[16] ? TIMER_MAX : sum[15:0];
            case (btn_phase[b])
                PH_DEB_PRESS: begin
                    if (t > settle_press) begin
                        btn_phase[b] = PH_AWAIT_RELEASE;
                        t = '0;
                    end
                end
                PH_AWAIT_RELEASE: begin
                    if (!pressed) begin
                        btn_phase[b] = PH_DEB_RELEASE;
                        t = '0;
                    end else if (t > hold_period) begin
                        btn_held[b] = 1'b1;
                        t = '0;
                        found[n] = '{3'(b), EV_HOLD, 4'd0, 1'b0};
                        n++;
                    end
                end
                PH_DEB_RELEASE: begin
                    if (t > settle_release) begin
                        // A release after a hold goes straight back to await
                        // press and counts no click.
                        if (btn_held[b]) begin
                            btn_phase[b] = PH_AWAIT_PRESS;
                            btn_held[b] = 1'b0;
                            btn_clicks[b] = '0;
                            found[n] = '{3'(b), EV_HOLD_RELEASE, 4'd0, 1'b0};
                            n++;
                        end else begin
                            if (btn_clicks[b] < click_cap)
                                btn_clicks[b] = btn_clicks[b] + 4'd1;
                            else
                                btn_clicks[b] = click_cap;
                            btn_phase[b] = PH_AWAIT_MULTI;
                        end
                        t = '0;
                    end
                end
                PH_AWAIT_MULTI: begin
                    if (pressed) begin
                        btn_phase[b] = PH_DEB_PRESS;
                        t = '0;
                    end else if (t > quiet_gap) begin
                        btn_phase[b] = PH_AWAIT_PRESS;
                        found[n] = '{3'(b), EV_CLICKS, btn_clicks[b], 1'b0};
                        n++;
                    end
                end
                default: begin
                    btn_phase[b] = PH_AWAIT_PRESS;
                    btn_clicks[b] = '0;
                    btn_held[b] = 1'b0;
                    if (pressed) begin
                        btn_phase[b] = PH_DEB_PRESS;
                        t = '0;
                    end
                end
            endcase
            btn_timer[b] = t;
        end
        if (n > 0)
            found[n - 1].last = 1'b1;
        for (int k = 0; k < n; k++)
            pending_events.push_back(found[k]);
    endfunction

    // Idle cycles before the next item; now and then a burst with none at all.
    function automatic int pick_gap(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst_left = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    // ------------------------------------------------------------------
    // Monitor. Everything is sampled at the rising edge, where the inputs
    // have been stable since the falling edge. Register writes and ticks
    // update the model; each result item is checked against the oldest
    // expected event.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        btn_event_t got_ev;
        btn_event_t want_ev;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ACTIVE_LEVELS: pressed_level = cfg_data[7:0];
                    REG_DEB_PRESS:     settle_press = cfg_data;
                    REG_DEB_RELEASE:   settle_release = cfg_data;
                    REG_HOLD:          hold_period = cfg_data;
                    REG_MULTI_CLICK:   quiet_gap = cfg_data;
                    REG_MAX_CLICKS:    click_cap = cfg_data[3:0];
                    default: ;
                endcase
                cfg_writes++;
            end
            if (s_valid && s_ready) begin
                advance_buttons(s_elapsed_ms, s_button_levels);
                ticks_taken++;
            end
            if (m_valid && m_ready) begin
                events_taken++;
                got_ev = '{m_button_index, m_event_kind, m_click_count, m_last};
                if (pending_events.size() == 0) begin
                    flag_mismatch($sformatf("unexpected event: button %0d kind %0d count %0d",
                                            got_ev.button, got_ev.kind, got_ev.count));
                end else begin
                    want_ev = pending_events.pop_front();
                    if (got_ev.button !== want_ev.button)
                        flag_mismatch($sformatf("button_index %0d, expected %0d",
                                                got_ev.button, want_ev.button));
                    if (got_ev.kind !== want_ev.kind)
                        flag_mismatch($sformatf("event_kind %0d, expected %0d (button %0d)",
                                                got_ev.kind, want_ev.kind, want_ev.button));
                    if (got_ev.count !== want_ev.count)
                        flag_mismatch($sformatf("click_count %0d, expected %0d (button %0d)",
                                                got_ev.count, want_ev.count, want_ev.button));
                    if (got_ev.last !== want_ev.last)
                        flag_mismatch($sformatf("last %0b, expected %0b (button %0d)",
                                                got_ev.last, want_ev.last, want_ev.button));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tick driver. It works at the falling edge: once the current item has
    // been taken it waits a drawn number of cycles, then offers the next
    // item from the queue and holds it until the block takes it. When the
    // next item follows with no gap, s_valid simply stays high.
    // ------------------------------------------------------------------
    int    tx_seen  = 0;
    int    tx_wait  = 0;
    int    tx_burst = 0;
    logic  tx_busy  = 1'b0;
    tick_t tx_item  = '0;

    always @(negedge aclk) begin
        if (tx_seen != ticks_taken) begin
            tx_seen = ticks_taken;
            tx_busy = 1'b0;
            tx_wait = pick_gap(tx_burst);
        end
        if (aresetn && !tx_busy) begin
            if (tx_wait > 0) begin
                tx_wait--;
            end else if (pending_ticks.size() > 0) begin
                tx_item = pending_ticks.pop_front();
                tx_busy = 1'b1;
            end
        end
        s_valid <= tx_busy;
        s_elapsed_ms <= tx_item.elapsed;
        s_button_levels <= tx_item.levels;
    end

    // ------------------------------------------------------------------
    // Result receiver. After each item it takes, it holds m_ready low for
    // a drawn number of cycles. Once in the run it also holds off for a
    // long stretch while the sender keeps offering ticks.
    // ------------------------------------------------------------------
    int rx_seen       = 0;
    int rx_wait       = 0;
    int rx_burst      = 0;
    int rx_stall_left = 0;
    bit rx_stall_done = 1'b0;

    always @(negedge aclk) begin
        if (rx_seen != events_taken) begin
            rx_seen = events_taken;
            rx_wait = pick_gap(rx_burst);
        end
        if (!rx_stall_done && ticks_taken >= LONG_STALL_AT) begin
            rx_stall_done = 1'b1;
            rx_stall_left = LONG_STALL_CYCLES;
        end
        if (rx_stall_left > 0) begin
            rx_stall_left--;
            m_ready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        int before_cnt;
        @(negedge aclk);
        before_cnt = cfg_writes;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        while (cfg_writes == before_cnt)
            @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_timing(input logic [15:0] levels, input logic [15:0] press_ms,
                              input logic [15:0] release_ms, input logic [15:0] hold,
                              input logic [15:0] multi, input logic [15:0] cap);
        write_reg(REG_ACTIVE_LEVELS, levels);
        write_reg(REG_DEB_PRESS, press_ms);
        write_reg(REG_DEB_RELEASE, release_ms);
        write_reg(REG_HOLD, hold);
        write_reg(REG_MULTI_CLICK, multi);
        write_reg(REG_MAX_CLICKS, cap);
    endtask

    task automatic add_tick(input logic [15:0] elapsed, input logic [7:0] levels);
        pending_ticks.push_back('{elapsed, levels});
    endtask

    // Random ticks that follow believable press and release patterns: each
    // button flips its logical state now and then, and the raw levels are
    // derived from the active levels. A few ticks carry random levels or
    // very long gaps to break the sequences up.
    task automatic queue_random_ticks(input int count, input int max_step,
                                      input int flip_pct, input logic [7:0] act);
        tick_t tk;
        int    roll;
        repeat (count) begin
            for (int b = 0; b < 8; b++)
                if ($urandom_range(0, 99) < flip_pct)
                    finger_down[b] = ~finger_down[b];
            roll = $urandom_range(0, 39);
            if (roll == 0)
                tk.elapsed = TIMER_MAX;
            else if (roll == 1)
                tk.elapsed = 16'($urandom);
            else
                tk.elapsed = 16'($urandom_range(0, max_step));
            if (roll == 2 || roll == 3)
                tk.levels = 8'($urandom);
            else
                tk.levels = ~(finger_down ^ act);
            pending_ticks.push_back(tk);
        end
    endtask

    // Lets the sender run dry and every expected event arrive, then waits a
    // few more cycles so that ticks without events have left the pipeline.
    task automatic wait_until_idle();
        int waited;
        waited = 0;
        while ((pending_ticks.size() != 0 || tx_busy || pending_events.size() != 0)
               && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        if (pending_events.size() != 0) begin
            flag_mismatch($sformatf("%0d expected events never arrived",
                                    pending_events.size()));
            pending_events.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        // Model state after reset: defaults in the registers, every button
        // waiting for a press with a cleared timer.
        pressed_level = 8'h00;
        settle_press = 16'd50;
        settle_release = 16'd50;
        hold_period = 16'd1000;
        quiet_gap = 16'd300;
        click_cap = 4'd5;
        for (int b = 0; b < 8; b++) begin
            btn_phase[b] = PH_AWAIT_PRESS;
            btn_clicks[b] = '0;
            btn_held[b] = 1'b0;
            btn_timer[b] = '0;
        end

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part on the reset settings, where a low level means pressed.
        // All eight buttons pressed together and held past the hold period
        // twice, so each of those ticks yields a full batch of eight hold events; then
        // released after the hold.
        add_tick(16'd0, 8'hFF);
        add_tick(16'd0, 8'h00);
        add_tick(16'd51, 8'h00);
        add_tick(16'd1001, 8'h00);
        add_tick(16'd1001, 8'h00);
        add_tick(16'd0, 8'hFF);
        add_tick(16'd51, 8'hFF);
        // A double click on button 0 that ends when the quiet window closes.
        add_tick(16'd0, 8'hFE);
        add_tick(16'd60, 8'hFE);
        add_tick(16'd10, 8'hFF);
        add_tick(16'd60, 8'hFF);
        add_tick(16'd10, 8'hFE);
        add_tick(16'd60, 8'hFE);
        add_tick(16'd0, 8'hFF);
        add_tick(16'd60, 8'hFF);
        add_tick(16'd301, 8'hFF);
        // Longest gaps: timers saturate, alternating buttons hold and click.
        add_tick(16'hFFFF, 8'h55);
        add_tick(16'hFFFF, 8'h55);
        add_tick(16'hFFFF, 8'h55);
        add_tick(16'hFFFF, 8'hAA);
        add_tick(16'hFFFF, 8'hAA);
        add_tick(16'd0, 8'hFF);
        add_tick(16'd51, 8'hFF);
        add_tick(16'd301, 8'hFF);
        wait_until_idle();

        // Active-high buttons with zero debounce on both edges and a large
        // click limit.
        set_timing(16'h00FF, 16'd0, 16'd0, 16'd30, 16'd20, 16'h000F);
        queue_random_ticks(50, 6, 15, 8'hFF);
        wait_until_idle();

        // Mixed active levels and a click limit of one; the upper data bits
        // are set to show they are ignored, and the two unused register
        // indexes are written, which must change nothing.
        set_timing(16'hFF5A, 16'd5, 16'd7, 16'd60, 16'd25, 16'hFFF1);
        write_reg(3'd6, 16'hFFFF);
        write_reg(3'd7, 16'hFFFF);
        queue_random_ticks(50, 8, 12, 8'h5A);
        wait_until_idle();

        // Every threshold at its maximum: a saturated timer never exceeds it.
        set_timing(16'hFF00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h000F);
        queue_random_ticks(15, 65535, 25, 8'h00);
        wait_until_idle();

        // A click limit of zero, so every finished sequence reports no clicks.
        set_timing(16'h00A5, 16'd2, 16'd2, 16'd25, 16'd12, 16'h0000);
        queue_random_ticks(40, 5, 20, 8'hA5);
        wait_until_idle();

        // Zero hold period and quiet window: holds repeat on every tick that
        // advances time, and click sequences end at once.
        set_timing(16'h00C3, 16'd10, 16'd3, 16'd0, 16'd0, 16'h0003);
        queue_random_ticks(40, 10, 8, 8'hC3);
        wait_until_idle();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        #(WATCHDOG_CYCLES * 10);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
design/mcbd_pkg.sv
design/mcbd_lane.sv
design/mcbd_merge.sv
design/multi_click_button_detector.sv
tb/multi_click_button_detector_tb.sv
